// ===== rtl/vvpu_pkg.sv =====
// Package for the velocity Verlet particle update block.
// Holds widths, reset values, command codes, sequencer state type and divider request/response types.
`default_nettype none
package vvpu_pkg;

    localparam int unsigned MaxParticlesDefault = 1024;
    localparam int unsigned IndexWidth          = 10;
    localparam logic [15:0] TimeStepReset       = 16'd655;
    localparam logic [62:0] KineticMax          = {63{1'b1}};

    localparam logic CmdPosition = 1'b0;
    localparam logic CmdVelocity = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MEM_READ,
        ST_AXIS_START,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_AXIS_SUM,
        ST_SQ_MUL,
        ST_KIN_LO,
        ST_KIN_HI,
        ST_KIN_ACC,
        ST_OUT
    } vvpu_state_t;

    // Control handed from the sequencer to the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [48:0] divisor;
    } vvpu_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } vvpu_div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/velocity_verlet_particle_update.sv =====
// Velocity Verlet particle update, top level: sequencer, shared multiplier,
// force store and kinetic accumulator. Depends on vvpu_pkg and vvpu_divider.
//
//   channel   handshake                   payload
//   cfg       cfg_valid / cfg_ready       cfg_data (time step)
//   in        in_valid / in_ready         cmd, particle_index, mass, forces, pos, vel
//   out       out_valid / out_ready       out_x/y/z, kinetic_sum, saturated
//
// Each item runs three 64-step divisions, one per axis, through one
// radix-2 divider, plus a few shared 34x34 multiplies per axis.
// in_ready is high only in the idle state; the result register holds the item
// until it is taken, and a new item may be accepted in the same cycle.
// Reset clears control state and the kinetic sum and loads the time step.
`default_nettype none
module velocity_verlet_particle_update
    import vvpu_pkg::*;
#(
    parameter int unsigned MAX_PARTICLES = MaxParticlesDefault
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 cmd,
    input  wire logic [IndexWidth-1:0] particle_index,
    input  wire logic [30:0]          mass,
    input  wire logic signed [31:0]   force_x,
    input  wire logic signed [31:0]   force_y,
    input  wire logic signed [31:0]   force_z,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic signed [31:0]   vel_x,
    input  wire logic signed [31:0]   vel_y,
    input  wire logic signed [31:0]   vel_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        out_x,
    output logic signed [31:0]        out_y,
    output logic signed [31:0]        out_z,
    output logic [62:0]               kinetic_sum,
    output logic                      saturated
);

    localparam int unsigned Depth = (MAX_PARTICLES < (1 << IndexWidth)) ?
                                    MAX_PARTICLES : (1 << IndexWidth);
    localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

    // Force store, one word holding all three axes.
    logic [95:0] force_mem [Depth];
    logic [95:0] mem_rdata_reg;

    vvpu_state_t state_reg, state_next;
    logic [15:0] dt_reg;
    logic [63:0] kacc_reg, kacc_next;

    // Item registers.
    logic        cmd_reg;
    logic [IndexWidth-1:0] idx_reg;
    logic [30:0] m_reg;
    logic signed [31:0] f_reg [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] v_reg [3];
    logic [1:0]  axis_reg, axis_next;

    // Work registers.
    logic signed [32:0] s_reg, s_next;
    logic [32:0] mag_reg, mag_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [47:0] tv_reg, tv_next;
    logic signed [31:0] o_reg [3];
    logic signed [31:0] o_next;
    logic        sat_reg, sat_next;
    logic [63:0] sq_reg, sq_next;
    logic [63:0] klo_reg, klo_next;

    // Output register.
    logic        ovalid_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic [62:0] oks_reg;
    logic        osat_reg;

    // Shared multiplier: 34x34 signed, one product per cycle. The force sum
    // magnitude can reach 2^32, so operands carry one bit above 33.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    vvpu_div_req_t div_req;
    vvpu_div_rsp_t div_rsp;

    vvpu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic        in_acc;
    logic [30:0] m_eff;
    logic        idx_in_store;
    logic signed [31:0] saved_f;
    logic signed [63:0] qsig;
    logic signed [65:0] tot;
    logic [63:0] kterm;
    logic        kterm_sat;
    logic [64:0] kadd;
    logic [63:0] kacc_base;
    logic [31:0] oabs;

    assign in_ready     = (state_reg == ST_IDLE) && (!ovalid_reg || out_ready);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign in_acc       = in_valid && in_ready;
    assign m_eff        = (m_reg == '0) ? 31'd1 : m_reg;
    assign idx_in_store = ({22'd0, idx_reg} < 32'(Depth));

    always_comb
    begin
        case (axis_reg)
            2'd0:    saved_f = idx_in_store ? signed'(mem_rdata_reg[31:0])  : '0;
            2'd1:    saved_f = idx_in_store ? signed'(mem_rdata_reg[63:32]) : '0;
            default: saved_f = idx_in_store ? signed'(mem_rdata_reg[95:64]) : '0;
        endcase
    end

    // Sequencer and shared datapath.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        s_next     = s_reg;
        mag_next   = mag_reg;
        prod_next  = prod_reg;
        tv_next    = tv_reg;
        sat_next   = sat_reg;
        sq_next    = sq_reg;
        klo_next   = klo_reg;
        kacc_next  = kacc_reg;
        o_next     = '0;
        mul_a      = '0;
        mul_b      = '0;
        div_req    = '0;
        qsig       = '0;
        tot        = '0;
        kterm      = '0;
        kterm_sat  = 1'b0;
        kadd       = '0;
        kacc_base  = kacc_reg;
        oabs       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_MEM_READ;
                    axis_next  = 2'd0;
                    sat_next   = 1'b0;
                    sq_next    = '0;
                end
            end
            ST_MEM_READ:
                state_next = ST_AXIS_START;
            ST_AXIS_START:
            begin
                // Force sum or force, and its magnitude.
                if (cmd_reg == CmdVelocity)
                    s_next = 33'(saved_f) + 33'(f_reg[axis_reg]);
                else
                    s_next = 33'(f_reg[axis_reg]);
                mag_next   = s_next[32] ? 33'(-s_next) : 33'(s_next);
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                // dt * v for the position pass, dt * |s| otherwise.
                mul_a = signed'({18'd0, dt_reg});
                mul_b = (cmd_reg == CmdVelocity) ? signed'({1'b0, mag_reg})
                                                 : 34'(v_reg[axis_reg]);
                prod_next  = mul_p[63:0];
                tv_next    = 48'(mul_p >>> 16);
                state_next = (cmd_reg == CmdVelocity) ? ST_DIV_START : ST_MUL_B;
            end
            ST_MUL_B:
            begin
                mul_a = signed'({18'd0, dt_reg});
                mul_b = signed'({18'd0, dt_reg});
                prod_next  = mul_p[63:0];
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                mul_a = signed'({2'b00, prod_reg[31:0]});
                mul_b = signed'({1'b0, mag_reg});
                prod_next  = mul_p[63:0];
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = (cmd_reg == CmdVelocity) ? {17'd0, m_eff, 1'b0}
                                                            : {1'b0, m_eff, 17'd0};
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_AXIS_SUM;
            end
            ST_AXIS_SUM:
            begin
                if (cmd_reg == CmdPosition)
                begin
                    qsig = (div_rsp.quotient > 64'h100_0000_0000) ?
                           64'h100_0000_0000 : div_rsp.quotient;
                    if (s_reg[32])
                        qsig = -qsig;
                    tot = 66'(p_reg[axis_reg]) + 66'(tv_reg) + 66'(qsig);
                end
                else
                begin
                    qsig = signed'(div_rsp.quotient);
                    if (s_reg[32])
                        qsig = -qsig;
                    tot = 66'(v_reg[axis_reg]) + 66'(qsig);
                end
                if (tot > 66'sd2147483647)
                begin
                    o_next   = 32'h7FFF_FFFF;
                    sat_next = 1'b1;
                end
                else if (tot < -66'sd2147483648)
                begin
                    o_next   = 32'h8000_0000;
                    sat_next = 1'b1;
                end
                else
                    o_next = tot[31:0];
                if (cmd_reg == CmdVelocity)
                    state_next = ST_SQ_MUL;
                else if (axis_reg == 2'd2)
                    state_next = ST_OUT;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_AXIS_START;
                end
            end
            ST_SQ_MUL:
            begin
                // Square of the clipped new velocity, added to the sum.
                oabs  = o_reg[axis_reg][31] ? 32'(-o_reg[axis_reg])
                                            : 32'(o_reg[axis_reg]);
                mul_a = signed'({2'b00, oabs});
                mul_b = signed'({2'b00, oabs});
                sq_next = sq_reg + mul_p[63:0];
                if (axis_reg == 2'd2)
                    state_next = ST_KIN_LO;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_AXIS_START;
                end
            end
            ST_KIN_LO:
            begin
                mul_a = signed'({3'b000, m_eff});
                mul_b = signed'({2'b00, sq_reg[31:0]});
                klo_next   = mul_p[63:0];
                state_next = ST_KIN_HI;
            end
            ST_KIN_HI:
            begin
                mul_a = signed'({3'b000, m_eff});
                mul_b = signed'({2'b00, sq_reg[63:32]});
                prod_next  = mul_p[63:0];
                state_next = ST_KIN_ACC;
            end
            ST_KIN_ACC:
            begin
                if (prod_reg >= 64'h1_0000_0000_0000)
                    kterm_sat = 1'b1;
                else
                begin
                    kterm = {prod_reg[48:0], 15'd0} + {17'd0, klo_reg[63:17]};
                    if (kterm > {1'b0, KineticMax})
                        kterm_sat = 1'b1;
                end
                if (kterm_sat)
                begin
                    kterm    = {1'b0, KineticMax};
                    sat_next = 1'b1;
                end
                kacc_base = (idx_reg == '0) ? 64'd0 : kacc_reg;
                kadd      = {1'b0, kacc_base} + {1'b0, kterm};
                if (kadd > {2'b00, KineticMax})
                begin
                    kacc_next = {1'b0, KineticMax};
                    sat_next  = 1'b1;
                end
                else
                    kacc_next = kadd[63:0];
                state_next = ST_OUT;
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dt_reg     <= TimeStepReset;
            kacc_reg   <= '0;
            ovalid_reg <= 1'b0;
            axis_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            kacc_reg  <= kacc_next;
            if (cfg_valid && cfg_ready)
                dt_reg <= cfg_data;
            if (state_reg == ST_OUT)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Payload and work registers.
    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        mag_reg <= mag_next;
        prod_reg <= prod_next;
        tv_reg  <= tv_next;
        sat_reg <= sat_next;
        sq_reg  <= sq_next;
        klo_reg <= klo_next;
        if (state_reg == ST_AXIS_SUM)
            o_reg[axis_reg] <= o_next;
        if (in_acc)
        begin
            cmd_reg  <= cmd;
            idx_reg  <= particle_index;
            m_reg    <= mass;
            f_reg[0] <= force_x;
            f_reg[1] <= force_y;
            f_reg[2] <= force_z;
            p_reg[0] <= pos_x;
            p_reg[1] <= pos_y;
            p_reg[2] <= pos_z;
            v_reg[0] <= vel_x;
            v_reg[1] <= vel_y;
            v_reg[2] <= vel_z;
        end
        if (state_reg == ST_OUT)
        begin
            ox_reg   <= o_reg[0];
            oy_reg   <= o_reg[1];
            oz_reg   <= o_reg[2];
            oks_reg  <= (cmd_reg == CmdVelocity) ? kacc_reg[62:0] : '0;
            osat_reg <= sat_reg;
        end
    end

    // Force store: read in the state after accept, written at the end of a position pass.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MEM_READ)
            mem_rdata_reg <= force_mem[idx_reg[AddrW-1:0]];
        if (state_reg == ST_OUT && cmd_reg == CmdPosition && idx_in_store)
            force_mem[idx_reg[AddrW-1:0]] <= {f_reg[2], f_reg[1], f_reg[0]};
    end

    assign out_valid   = ovalid_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_z       = oz_reg;
    assign kinetic_sum = oks_reg;
    assign saturated   = osat_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input taken outside idle");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_OUT)
        else $error("result shown without finishing the sequence");
    a_kacc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kacc_reg[63] == 1'b0)
        else $error("kinetic sum exceeds its range");
    a_div_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("division finished outside the wait state");
`endif

endmodule
`default_nettype wire

// ===== rtl/vvpu_divider.sv =====
// Radix-2 restoring divider, 64-bit dividend, 49-bit divisor.
// Depends on vvpu_pkg for the request and response structs.
`default_nettype none
module vvpu_divider
    import vvpu_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  vvpu_div_req_t      req,
    output vvpu_div_rsp_t      rsp
);

    logic [63:0] quo_reg, quo_next;
    logic [49:0] rem_reg, rem_next;
    logic [48:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [49:0] trial;
    logic [50:0] diff;

    // One quotient bit per cycle while busy.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[48:0], quo_reg[63]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[50])
            begin
                rem_next = diff[49:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !rsp.busy && $past(busy_reg))
        else $error("divider done without a preceding busy cycle");
    a_count_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !req.start |=> !busy_reg)
        else $error("divider became busy without a start");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 7'd0)
        else $error("divider busy with zero count");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for velocity_verlet_particle_update.
// Drives random and directed particle items, predicts each result in place.
// Depends on vvpu_pkg and the block's RTL only.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import vvpu_pkg::*;

    localparam int NumRandom = 1600;
    localparam int StallLimit = 20000;
    localparam logic [63:0] KMax = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  idx;
        logic [30:0] mass;
        logic signed [31:0] fx, fy, fz, px, py, pz, vx, vy, vz;
    } particle_t;

    typedef struct packed {
        logic signed [31:0] x, y, z;
        logic [62:0] ksum;
        logic        sat;
    } update_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    logic cfg_ready;
    logic in_valid = 1'b0;
    logic in_ready;
    particle_t drv = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] out_x, out_y, out_z;
    logic [62:0] kinetic_sum;
    logic saturated;

    velocity_verlet_particle_update u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(drv.cmd), .particle_index(drv.idx), .mass(drv.mass),
        .force_x(drv.fx), .force_y(drv.fy), .force_z(drv.fz),
        .pos_x(drv.px), .pos_y(drv.py), .pos_z(drv.pz),
        .vel_x(drv.vx), .vel_y(drv.vy), .vel_z(drv.vz),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .kinetic_sum(kinetic_sum), .saturated(saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: time step, stored forces and kinetic energy sum.
    logic [15:0] dt_model;
    logic signed [31:0] force_store [3][1024];
    logic [63:0] energy_sum;

    particle_t pending_items[$];
    update_t expected_updates[$];
    int errors = 0;
    int accepted = 0;
    int received = 0;
    int idle_cycles = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [63:0] clip_word(logic signed [63:0] x, ref bit sat);
        if (x > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
        if (x < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
        return x;
    endfunction

    // New position along one axis.
    function automatic logic signed [31:0] drift_axis(logic signed [63:0] r,
        logic signed [63:0] v, logic signed [63:0] f, logic [63:0] m, ref bit sat);
        logic signed [63:0] tv, tf;
        logic [63:0] mag, q;
        logic [127:0] num;
        tv = ($signed({48'd0, dt_model}) * v) >>> 16;
        mag = (f < 0) ? -f : f;
        num = {64'd0, dt_model} * dt_model * mag;
        q = 64'(num / ({64'd0, m} << 17));
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        tf = (f < 0) ? -$signed(q) : $signed(q);
        return 32'(clip_word(r + tv + tf, sat));
    endfunction

    // New velocity along one axis.
    function automatic logic signed [31:0] kick_axis(logic signed [63:0] v,
        logic signed [63:0] s, logic [63:0] m, ref bit sat);
        logic [63:0] mag, q;
        logic signed [63:0] d;
        mag = (s < 0) ? -s : s;
        q = (dt_model * mag) / (m << 1);
        d = (s < 0) ? -$signed(q) : $signed(q);
        return 32'(clip_word(v + d, sat));
    endfunction

    function automatic update_t predict_update(particle_t p);
        update_t u;
        bit sat;
        logic [63:0] m, sq, term;
        logic [127:0] prod;
        logic signed [63:0] s;
        logic signed [31:0] o [3];
        logic signed [31:0] fn [3], po [3], ve [3];
        sat = 0;
        m = (p.mass == 0) ? 64'd1 : {33'd0, p.mass};
        fn = '{p.fx, p.fy, p.fz};
        po = '{p.px, p.py, p.pz};
        ve = '{p.vx, p.vy, p.vz};
        u.ksum = '0;
        if (p.cmd == CmdPosition) begin
            for (int k = 0; k < 3; k++)
                o[k] = drift_axis(po[k], ve[k], fn[k], m, sat);
            for (int k = 0; k < 3; k++) force_store[k][p.idx] = fn[k];
        end else begin
            sq = 0;
            for (int k = 0; k < 3; k++) begin
                s = 64'(force_store[k][p.idx]) + 64'(fn[k]);
                o[k] = kick_axis(ve[k], s, m, sat);
                sq += 64'(64'(o[k]) * 64'(o[k]));
            end
            prod = ({64'd0, m} * sq) >> 17;
            if (prod > {64'd0, KMax}) begin sat = 1; term = KMax; end
            else term = prod[63:0];
            if (p.idx == 0) energy_sum = 0;
            if (energy_sum > KMax - term) begin energy_sum = KMax; sat = 1; end
            else energy_sum += term;
            u.ksum = energy_sum[62:0];
        end
        u.x = o[0]; u.y = o[1]; u.z = o[2];
        u.sat = sat;
        return u;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2000) - 1000;
            3: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_mass();
        case ($urandom_range(0, 4))
            0: return 31'd0;
            1: return 31'($urandom_range(1, 4));
            2: return 31'h7FFF_FFFF;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic particle_t rand_particle(logic c, logic [9:0] i);
        particle_t p;
        p.cmd = c; p.idx = i; p.mass = rand_mass();
        p.fx = rand_word(); p.fy = rand_word(); p.fz = rand_word();
        p.px = rand_word(); p.py = rand_word(); p.pz = rand_word();
        p.vx = rand_word(); p.vy = rand_word(); p.vz = rand_word();
        return p;
    endfunction

    // Driver: presents pending items with random gaps.
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            expected_updates.push_back(predict_update(drv));
            accepted++;
        end
        if (!in_valid || in_ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                drv <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_gap <= gap_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and field-by-field compare.
    always @(posedge clk)
    begin
        update_t e;
        if (out_valid && out_ready) begin
            received++;
            if (expected_updates.size() == 0) begin
                $display("%0t: unexpected item x=%h", $time, out_x);
                errors++;
            end else begin
                e = expected_updates.pop_front();
                if (out_x !== e.x) begin
                    $display("%0t: out_x exp %h got %h", $time, e.x, out_x); errors++;
                end
                if (out_y !== e.y) begin
                    $display("%0t: out_y exp %h got %h", $time, e.y, out_y); errors++;
                end
                if (out_z !== e.z) begin
                    $display("%0t: out_z exp %h got %h", $time, e.z, out_z); errors++;
                end
                if (kinetic_sum !== e.ksum) begin
                    $display("%0t: kinetic_sum exp %h got %h", $time, e.ksum, kinetic_sum);
                    errors++;
                end
                if (saturated !== e.sat) begin
                    $display("%0t: saturated exp %b got %b", $time, e.sat, saturated);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0 && $time < 100);
    end

    // Watchdog on cycles without any handshake on the cfg, in or out channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_time_step(logic [15:0] value);
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dt_model = value;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_updates.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    // Position pass over a small set of particles, then their velocity pass.
    task automatic queue_sweep(int count);
        logic [9:0] ids [$];
        logic [9:0] base;
        base = 10'($urandom_range(0, 1023 - count));
        if ($urandom_range(0, 2) == 0) base = 0;
        for (int i = 0; i < count; i++) ids.push_back(base + 10'(i));
        foreach (ids[i]) pending_items.push_back(rand_particle(CmdPosition, ids[i]));
        foreach (ids[i]) pending_items.push_back(rand_particle(CmdVelocity, ids[i]));
    endtask

    initial
    begin
        logic [15:0] steps [4];
        particle_t p;
        dt_model = TimeStepReset;
        energy_sum = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, both passes, zero mass, index restart, top index.
        p = rand_particle(CmdPosition, 10'd0);
        p.mass = 0; p.fx = 32'h7FFF_FFFF; p.fy = 32'h8000_0000; p.fz = 0;
        p.px = 32'h7FFF_FFFF; p.py = 32'h8000_0000; p.vx = 32'h7FFF_FFFF;
        pending_items.push_back(p);
        p.cmd = CmdVelocity; p.vy = 32'h8000_0000;
        pending_items.push_back(p);
        p = rand_particle(CmdPosition, 10'd1023); p.mass = 31'h7FFF_FFFF;
        pending_items.push_back(p);
        p.cmd = CmdVelocity; p.fx = 32'h8000_0000;
        pending_items.push_back(p);
        p = rand_particle(CmdPosition, 10'd1); p.mass = 1;
        p.fx = 32'h7FFF_FFFF; p.fy = 32'h7FFF_FFFF; p.fz = 32'h7FFF_FFFF;
        pending_items.push_back(p);
        p.cmd = CmdVelocity; p.vx = 32'h7FFF_FFFF; p.vy = 32'h7FFF_FFFF;
        pending_items.push_back(p);
        p.idx = 10'd0;
        pending_items.push_back(p);
        drain();

        // Random sweeps across several time steps, extremes among them.
        steps = '{16'd1, 16'hFFFF, 16'd655, 16'($urandom_range(1, 65535))};
        foreach (steps[s]) begin
            write_time_step(steps[s]);
            for (int n = 0; n < NumRandom / 4; ) begin
                int c;
                c = $urandom_range(1, 12);
                queue_sweep(c);
                n += 2 * c;
            end
            drain();
        end

        $display("Ran %0d items over %0d time step settings, %0d results checked.",
                 accepted, 5, received);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/vvpu_pkg.sv
rtl/vvpu_divider.sv
rtl/velocity_verlet_particle_update.sv
verif/tb_top.sv
